/* hdl/assert_macros.svh */
// Assertion macros used by the interpolator controller.
// They expect clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// When pre holds, post holds at the next edge.
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

/* hdl/isi_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the cubic weight table of the interpolator.
// No dependencies.
package isi_pkg;

	localparam int FracBits  = 8;
	localparam int TapCount  = 16;
	localparam int DrainCycles = 4;
	localparam logic [16:0] OneQ16 = 17'd65536;
	localparam logic [15:0] Q8Max  = 16'd65280;

	// register indexes
	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_CHANNEL = 2'd2;
	localparam logic [1:0] REG_MODE    = 2'd3;

	// request kinds
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef logic signed [17:0] wgt_t;

	// saturated configuration as seen by the datapath
	typedef struct packed {
		logic [8:0] width;
		logic [8:0] height;
		logic [2:0] chans;
		logic       bicubic;
	} cfg_t;

	typedef struct packed {
		logic       wr;      // store pixel byte from input
		logic       latch;   // capture sample request
		logic       load;    // compute weights and range check
		logic       issue;   // read one neighbor tap
		logic [3:0] tap;     // {row, column} of the tap
	} cmd_t;

	typedef struct packed {
		logic outside;
	} sts_t;

	// {w3, w2, w0} per fraction, Q16
	typedef logic [255:0][53:0] wtab_t;

	localparam longint CubicDen  = longint'(6) <<< 32;
	localparam longint CubicHalf = longint'(3) <<< 32;

	function automatic longint floor_den(input longint n);
		longint q;
		q = n / CubicDen;
		if ((n % CubicDen) != 0 && n < 0) q = q - 1;
		return q;
	endfunction

	function automatic wtab_t build_cubic_tab();
		wtab_t  tab;
		longint t, s, t3, t2s, ts2, w0, w2, w3;
		s = 65536;
		for (int f = 0; f < 256; f++) begin
			t   = longint'(f) <<< (16 - FracBits);
			t3  = t * t * t;
			t2s = t * t * s;
			ts2 = t * s * s;
			w0  = floor_den(-t3 + 3 * t2s - 2 * ts2 + CubicHalf);
			w2  = floor_den(-3 * t3 + 3 * t2s + 6 * ts2 + CubicHalf);
			w3  = floor_den(t3 - ts2 + CubicHalf);
			tab[f] = {w3[17:0], w2[17:0], w0[17:0]};
		end
		return tab;
	endfunction

	localparam wtab_t CUBIC_TAB = build_cubic_tab();

endpackage

/* hdl/isi_dp.sv */
`timescale 1ns / 1ps
// Datapath: pixel memory, weight registers, tap MAC pipeline, rounding.
// Depends on isi_pkg.
module isi_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  isi_pkg::cmd_t      cmd,
	input  isi_pkg::cfg_t      cfg,
	input  logic [7:0]         pixel_col,
	input  logic [7:0]         pixel_row,
	input  logic [1:0]         channel,
	input  logic [7:0]         pixel_value,
	input  logic signed [16:0] coord_x,
	input  logic signed [16:0] coord_y,
	output isi_pkg::sts_t      sts,
	output logic [15:0]        result
);

	logic [7:0] mem [0:262143];

	logic signed [8:0]  ix_q, iy_q;
	logic [7:0]         dx_q, dy_q;
	logic [1:0]         ch_q;
	isi_pkg::wgt_t      wx_q [4];
	isi_pkg::wgt_t      wy_q [4];
	logic               outside_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ix_q <= coord_x[16:8];
			iy_q <= coord_y[16:8];
			dx_q <= coord_x[7:0];
			dy_q <= coord_y[7:0];
			ch_q <= channel;
		end
	end

	// weights and range check
	logic signed [10:0] ixe, iye, we, he;
	logic               out_c;
	logic [53:0]        cx, cy;
	isi_pkg::wgt_t      wx_c [4];
	isi_pkg::wgt_t      wy_c [4];

	always_comb begin
		ixe = 11'(ix_q);
		iye = 11'(iy_q);
		we  = signed'({2'b00, cfg.width});
		he  = signed'({2'b00, cfg.height});
		out_c = ({1'b0, ch_q} >= cfg.chans) || ixe >= we || iye >= he;
		if (cfg.bicubic) begin
			out_c = out_c || ixe < 11'sd1 || iye < 11'sd1
				|| (dx_q != 8'd0 && ixe + 11'sd2 >= we)
				|| (dy_q != 8'd0 && iye + 11'sd2 >= he);
		end else begin
			out_c = out_c || ixe < 11'sd0 || iye < 11'sd0
				|| (dx_q != 8'd0 && ixe + 11'sd1 >= we)
				|| (dy_q != 8'd0 && iye + 11'sd1 >= he);
		end
		cx = isi_pkg::CUBIC_TAB[dx_q];
		cy = isi_pkg::CUBIC_TAB[dy_q];
		if (cfg.bicubic) begin
			wx_c[0] = cx[17:0];
			wx_c[2] = cx[35:18];
			wx_c[3] = cx[53:36];
			wy_c[0] = cy[17:0];
			wy_c[2] = cy[35:18];
			wy_c[3] = cy[53:36];
		end else begin
			wx_c[0] = '0;
			wx_c[2] = signed'({2'b00, dx_q, 8'h00});
			wx_c[3] = '0;
			wy_c[0] = '0;
			wy_c[2] = signed'({2'b00, dy_q, 8'h00});
			wy_c[3] = '0;
		end
		// center weight makes the row sum exactly one
		wx_c[1] = signed'({1'b0, isi_pkg::OneQ16}) - wx_c[0] - wx_c[2] - wx_c[3];
		wy_c[1] = signed'({1'b0, isi_pkg::OneQ16}) - wy_c[0] - wy_c[2] - wy_c[3];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wx_q      <= wx_c;
			wy_q      <= wy_c;
			outside_q <= out_c;
		end
	end

	assign sts.outside = outside_q;

	// memory write and tap read
	logic [7:0] rd_row, rd_col;
	logic [1:0] tj, tk;
	logic       en_c;

	assign tj     = cmd.tap[3:2];
	assign tk     = cmd.tap[1:0];
	assign rd_row = iy_q[7:0] + {6'd0, tj} - 8'd1;
	assign rd_col = ix_q[7:0] + {6'd0, tk} - 8'd1;
	assign en_c   = (wx_q[tk] != '0) && (wy_q[tj] != '0);

	logic [7:0] rd_s1;
	logic       en_s1, vld_s1;
	logic [1:0] j_s1, k_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[{pixel_row, pixel_col, channel}] <= pixel_value;
		if (cmd.issue && en_c) rd_s1 <= mem[{rd_row, rd_col, ch_q}];
		en_s1 <= en_c;
		j_s1  <= tj;
		k_s1  <= tk;
	end

	// stage 2: pixel times column weight
	logic signed [26:0] prod_s2;
	logic               vld_s2;
	logic [1:0]         j_s2, k_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= en_s1 ? signed'({1'b0, rd_s1}) * wx_q[k_s1] : 27'sd0;
		j_s2    <= j_s1;
		k_s2    <= k_s1;
	end

	// stage 3: row sum over four columns
	logic signed [28:0] vrun_q, vsum, rowv_s3;
	logic               vld_s3;
	logic [1:0]         j_s3;

	assign vsum = (k_s2 == 2'd0 ? 29'sd0 : vrun_q) + 29'(prod_s2);

	always_ff @(posedge clk) begin
		if (vld_s2) vrun_q <= vsum;
		if (vld_s2 && k_s2 == 2'd3) begin
			rowv_s3 <= vsum;
			j_s3    <= j_s2;
		end
	end

	// stage 4: row value times row weight
	logic signed [46:0] rowp_s4;
	logic               vld_s4;

	always_ff @(posedge clk) begin
		if (vld_s3) rowp_s4 <= rowv_s3 * wy_q[j_s3];
	end

	// stage 5: accumulate, Q32
	logic signed [48:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.load) acc_q <= '0;
		else if (vld_s4) acc_q <= acc_q + 49'(rowp_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && k_s2 == 2'd3;
			vld_s4 <= vld_s3;
		end
	end

	// round to Q8.8, ties up, clamp
	logic signed [48:0] rsum;
	logic signed [24:0] rq;

	always_comb begin
		rsum = acc_q + 49'sd8388608;
		rq   = rsum[48:24];
		if (outside_q || rq < 25'sd0) result = '0;
		else if (rq > signed'({9'd0, isi_pkg::Q8Max})) result = isi_pkg::Q8Max;
		else result = rq[15:0];
	end

endmodule

/* hdl/isi_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences write, load, sixteen tap reads, pipeline drain, output; outside skips reads and drain.
// Depends on isi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module isi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_kind,
	output logic          in_ready,
	input  logic          out_free,
	output logic          out_load,
	input  isi_pkg::sts_t sts,
	output isi_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       acc_in;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		cmd.tap   = cnt_q;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr    = acc_in && in_kind == isi_pkg::REQ_WRITE;
				cmd.latch = acc_in && in_kind == isi_pkg::REQ_SAMPLE;
				if (cmd.latch) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cnt_d    = '0;
				state_d  = ST_RUN;
			end
			ST_RUN: begin
				if (sts.outside) begin
					state_d = ST_DONE;
				end else begin
					cmd.issue = 1'b1;
					cnt_d     = cnt_q + 4'd1;
					if (cnt_q == 4'(isi_pkg::TapCount - 1)) begin
						cnt_d   = '0;
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'(isi_pkg::DrainCycles - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	`ASSERT_NEXT(a_outside_skips, state_q == ST_RUN && sts.outside, state_q == ST_DONE)
	`ASSERT_NEXT(a_drain_len, state_q == ST_DRAIN && cnt_q == 4'(isi_pkg::DrainCycles - 1), state_q == ST_DONE)
	`ASSERT_ALWAYS(a_cmd_excl, $onehot0({cmd.wr, cmd.latch, cmd.load, cmd.issue, out_load}))
	`ASSERT_NEXT(a_run_last, state_q == ST_RUN && !sts.outside && cnt_q == 4'd15, state_q == ST_DRAIN)

endmodule

/* hdl/image_sample_interpolator.sv */
`timescale 1ns / 1ps
// Sample request: load, 16 tap reads from the single-port pixel memory, MAC drain,
// output; a request found outside skips the tap reads and the drain.
// Pixel write: stored in memory as it is accepted. One item in work at a time; the read port sets the rate.
// The result register lets the next item enter while a result waits.
// arst_n clears control and the configuration registers to 256/256/1/bilinear; pixel memory is not cleared.
// Depends on isi_pkg, isi_ctrl, isi_dp.
module image_sample_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] pixel_col, [15:8] pixel_row, [17:16] channel, [25:18] pixel_value,
	// [42:26] coord_x, [59:43] coord_y, [63:60] zero
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,   // [0] req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample_value
	output logic        m_tuser,   // [0] outside
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers, raw
	logic [8:0] width_q, height_q;
	logic [2:0] chans_q;
	logic       mode_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			chans_q  <= 3'd1;
			mode_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				isi_pkg::REG_WIDTH:   width_q  <= pwdata[8:0];
				isi_pkg::REG_HEIGHT:  height_q <= pwdata[8:0];
				isi_pkg::REG_CHANNEL: chans_q  <= pwdata[2:0];
				isi_pkg::REG_MODE:    mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			isi_pkg::REG_WIDTH:   prdata = {23'd0, width_q};
			isi_pkg::REG_HEIGHT:  prdata = {23'd0, height_q};
			isi_pkg::REG_CHANNEL: prdata = {29'd0, chans_q};
			isi_pkg::REG_MODE:    prdata = {31'd0, mode_q};
			default:              prdata = '0;
		endcase
	end

	// saturate register values to their legal ranges
	isi_pkg::cfg_t cfg;

	always_comb begin
		cfg.width   = (width_q == 9'd0) ? 9'd1 : (width_q > 9'd256 ? 9'd256 : width_q);
		cfg.height  = (height_q == 9'd0) ? 9'd1 : (height_q > 9'd256 ? 9'd256 : height_q);
		cfg.chans   = (chans_q == 3'd0) ? 3'd1 : (chans_q > 3'd4 ? 3'd4 : chans_q);
		cfg.bicubic = mode_q;
	end

	isi_pkg::cmd_t cmd;
	isi_pkg::sts_t sts;
	logic          out_load, out_free;
	logic [15:0]   result;

	isi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.out_free (out_free),
		.out_load (out_load),
		.sts      (sts),
		.cmd      (cmd)
	);

	isi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.pixel_col   (s_tdata[7:0]),
		.pixel_row   (s_tdata[15:8]),
		.channel     (s_tdata[17:16]),
		.pixel_value (s_tdata[25:18]),
		.coord_x     (s_tdata[42:26]),
		.coord_y     (s_tdata[59:43]),
		.sts         (sts),
		.result      (result)
	);

	// output register: slot frees when the held transaction is taken
	logic        m_valid_q;
	logic [15:0] value_q;
	logic        outside_q;

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (out_load) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q   <= result;
			outside_q <= sts.outside;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = outside_q;

endmodule
